>>> sv/ipru_pkg.sv
// shared types, register indexes and helpers for the indexed pixel row unpacker
`default_nettype none

package ipru_pkg;

  localparam int MAX_COLUMNS_DEF   = 4096;
  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTES  = 2'd3;

  // pixel modes
  localparam logic [1:0] MODE_8BPP = 2'd0;
  localparam logic [1:0] MODE_4BPP = 2'd1;
  localparam logic [1:0] MODE_2BPP = 2'd2;
  localparam logic [1:0] MODE_1BPP = 2'd3;

  // operations
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] table_index;
  } ipru_in_t;

  typedef struct packed {
    logic [7:0] pixel_colour;
    logic       last_in_row;
    logic       last_in_image;
  } ipru_out_t;

  // table read request issued by the unpacker, one pixel each
  typedef struct packed {
    logic       en;
    logic [7:0] index;
    logic       row_end;
    logic       img_end;
  } ipru_rd_t;

  // table write request
  typedef struct packed {
    logic       en;
    logic [7:0] index;
    logic [7:0] colour;
  } ipru_wr_t;

  // colour of an entry that was never written
  function automatic logic [7:0] reset_colour(input logic [7:0] idx);
    reset_colour = (idx < 8'd16) ? idx : 8'd0;
  endfunction

endpackage

`default_nettype wire

>>> sv/ipru_colour_table.sv
// colour table memory with per-entry written flags and reset-value fallback
`default_nettype none

module ipru_colour_table #(
  parameter int TABLE_ENTRIES = ipru_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ipru_pkg::ipru_wr_t wr,
  input  wire ipru_pkg::ipru_rd_t rd,
  output logic [7:0]          rd_colour
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [7:0]               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written_r;

  logic [7:0]    data_r;
  logic          written_q_r;
  logic          in_range_r;
  logic [AW-1:0] addr_r;

  logic wr_ok;
  logic rd_ok;

  assign wr_ok = wr.en && (int'(wr.index) < TABLE_ENTRIES);
  assign rd_ok = int'(rd.index) < TABLE_ENTRIES;

  // read before write on a same-entry collision keeps item order
  always_ff @(posedge clk) begin
    if (rd.en) begin
      data_r     <= mem[rd.index[AW-1:0]];
      addr_r     <= rd.index[AW-1:0];
      in_range_r <= rd_ok;
    end
    if (wr_ok) begin
      mem[wr.index[AW-1:0]] <= wr.colour;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r   <= '0;
      written_q_r <= 1'b0;
    end else begin
      if (rd.en) begin
        written_q_r <= written_r[rd.index[AW-1:0]];
      end
      if (wr_ok) begin
        written_r[wr.index[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (!in_range_r) begin
      rd_colour = 8'd0;
    end else if (written_q_r) begin
      rd_colour = data_r;
    end else begin
      rd_colour = ipru_pkg::reset_colour(8'(addr_r));
    end
  end

endmodule

`default_nettype wire

>>> sv/ipru_unpacker.sv
// byte unpacker: field sequencer, row and image counters, padding skip
`default_nettype none

module ipru_unpacker #(
  parameter int MAX_COLUMNS = ipru_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ipru_pkg::ipru_in_t   in_data,
  input  wire logic                 issue_en,
  input  wire logic [1:0]           pixel_mode,
  input  wire logic [12:0]          columns,
  input  wire logic [12:0]          rows,
  input  wire logic [7:0]           pad_bytes,
  output ipru_pkg::ipru_rd_t        rd,
  output ipru_pkg::ipru_wr_t        wr
);

  logic        busy_r, busy_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  fld_r, fld_nxt;
  logic [12:0] col_r, col_nxt;
  logic [12:0] row_r, row_nxt;
  logic [7:0]  pad_r, pad_nxt;

  logic [12:0] col_total;
  logic [12:0] row_total;
  logic [13:0] col_inc;
  logic [13:0] row_inc;
  logic        issue;
  logic        row_end;
  logic        img_end;
  logic        last_fld;
  logic        done;
  logic        accept;
  logic [7:0]  field;
  logic [7:0]  byte_shift;
  logic [7:0]  pad_after;

  always_comb begin
    if (columns == 13'd0) begin
      col_total = 13'd1;
    end else if (int'(columns) > MAX_COLUMNS) begin
      col_total = 13'(MAX_COLUMNS);
    end else begin
      col_total = columns;
    end
    row_total = (rows == 13'd0) ? 13'd1 : rows;
  end

  // top field of the byte, and the byte moved on to the next field
  always_comb begin
    case (pixel_mode)
      ipru_pkg::MODE_8BPP: begin
        field      = byte_r;
        byte_shift = byte_r;
        last_fld   = 1'b1;
      end
      ipru_pkg::MODE_4BPP: begin
        field      = {4'd0, byte_r[7:4]};
        byte_shift = {byte_r[3:0], 4'd0};
        last_fld   = (fld_r == 3'd1);
      end
      ipru_pkg::MODE_2BPP: begin
        field      = {6'd0, byte_r[7:6]};
        byte_shift = {byte_r[5:0], 2'd0};
        last_fld   = (fld_r == 3'd3);
      end
      default: begin
        field      = {7'd0, byte_r[7]};
        byte_shift = {byte_r[6:0], 1'b0};
        last_fld   = (fld_r == 3'd7);
      end
    endcase
  end

  assign issue   = busy_r && issue_en;
  assign col_inc = {1'b0, col_r} + 14'd1;
  assign row_inc = {1'b0, row_r} + 14'd1;
  assign row_end = col_inc >= {1'b0, col_total};
  assign img_end = row_end && (row_inc >= {1'b0, row_total});
  assign done    = issue && (row_end || last_fld);

  assign in_ready = !busy_r || done;
  assign accept   = in_valid && in_ready;

  // padding count as it stands once the current pixel is issued
  assign pad_after = (issue && row_end && pixel_mode != ipru_pkg::MODE_8BPP) ?
                     pad_bytes : pad_r;

  always_comb begin
    busy_nxt = busy_r && !done;
    byte_nxt = issue ? byte_shift : byte_r;
    fld_nxt  = issue ? fld_r + 3'd1 : fld_r;
    pad_nxt  = pad_after;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (issue) begin
      if (row_end) begin
        col_nxt = 13'd0;
        row_nxt = img_end ? 13'd0 : row_inc[12:0];
      end else begin
        col_nxt = col_inc[12:0];
      end
    end
    if (accept && in_data.operation == ipru_pkg::OP_PIXEL) begin
      if (pad_after != 8'd0) begin
        pad_nxt = pad_after - 8'd1;
      end else begin
        busy_nxt = 1'b1;
        byte_nxt = in_data.data_byte;
        fld_nxt  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fld_r  <= 3'd0;
      col_r  <= 13'd0;
      row_r  <= 13'd0;
      pad_r  <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      fld_r  <= fld_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pad_r  <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    rd.en      = issue;
    rd.index   = field;
    rd.row_end = row_end;
    rd.img_end = img_end;
    wr.en      = accept && (in_data.operation == ipru_pkg::OP_TABLE);
    wr.index   = in_data.table_index;
    wr.colour  = in_data.data_byte;
  end

endmodule

`default_nettype wire

>>> sv/indexed_pixel_row_unpacker.sv
// Indexed pixel row unpacker. Each input word is either a pixel data byte or a
// colour table write. A data byte is split into 1, 2, 4 or 8 fields (8, 4, 2 or
// 1 bpp per the pixel_mode register), most significant field first; every
// field looks up the 256-entry colour table and leaves as one output word
// carrying the colour, a row-end flag and an image-end flag. Once a row's last
// column is out, the rest of that byte is dropped and, in the packed modes,
// the next pad_bytes data bytes are swallowed without output. Rate: the table
// has one read port and yields one pixel per cycle unless the output stalls;
// a data byte holds the unpacker until its pixels are issued (1 at 8 bpp, up
// to 2, 4 or 8 in the packed modes, fewer at a row end); the next byte is
// taken in the cycle its predecessor's last pixel is issued, so there is no
// bubble between bytes. Table writes and padding bytes emit no pixels. Results
// leave through a one-deep output register; the unpacker keeps going while it
// is empty or being drained. Table entries not yet written read as their reset
// value (entry i is i below 16, else 0) via per-entry written flags, so no
// clearing pass follows reset. Configuration writes go through the cfg port
// and must only happen while the block is idle.
`default_nettype none

module indexed_pixel_row_unpacker #(
  parameter int MAX_COLUMNS   = ipru_pkg::MAX_COLUMNS_DEF,
  parameter int TABLE_ENTRIES = ipru_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ipru_pkg::ipru_in_t             in_data,
  // output words
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ipru_pkg::ipru_out_t                 out_data,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [ipru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ipru_pkg::CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [1:0]  pixel_mode_r;
  logic [12:0] columns_r;
  logic [12:0] rows_r;
  logic [7:0]  pad_bytes_r;

  // output stage
  logic out_valid_r, out_valid_nxt;
  logic row_end_r;
  logic img_end_r;

  logic               issue_en;
  logic [7:0]         colour;
  ipru_pkg::ipru_rd_t rd;
  ipru_pkg::ipru_wr_t wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= ipru_pkg::MODE_8BPP;
      columns_r    <= 13'd1;
      rows_r       <= 13'd1;
      pad_bytes_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ipru_pkg::REG_PIXEL_MODE: pixel_mode_r <= cfg_data[1:0];
        ipru_pkg::REG_COLUMNS:    columns_r    <= cfg_data[12:0];
        ipru_pkg::REG_ROWS:       rows_r       <= cfg_data[12:0];
        ipru_pkg::REG_PAD_BYTES:  pad_bytes_r  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // a new pixel may be issued when the output register is free or draining;
  // the table read data register only moves on an issue, so a stalled word holds
  assign issue_en = !out_valid_r || out_ready;

  ipru_unpacker #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_unpacker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .issue_en   (issue_en),
    .pixel_mode (pixel_mode_r),
    .columns    (columns_r),
    .rows       (rows_r),
    .pad_bytes  (pad_bytes_r),
    .rd         (rd),
    .wr         (wr)
  );

  ipru_colour_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_colour_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd        (rd),
    .rd_colour (colour)
  );

  // flags are registered alongside the table read, so they stay with its colour
  always_comb begin
    if (rd.en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      row_end_r <= rd.row_end;
      img_end_r <= rd.img_end;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.pixel_colour  = colour;
  assign out_data.last_in_row   = row_end_r;
  assign out_data.last_in_image = img_end_r;

endmodule

`default_nettype wire
